>>> rtl/rlew_pkg.sv
// Shared widths, reset values, register indexes and the burst type of the word run encoder.
package rlew_pkg;

    localparam int WORD_W  = 16;
    localparam int RUN_W   = 13;
    localparam int MINR_W  = 3;
    localparam int CB_W    = 15;
    localparam int EB_W    = 14;
    localparam int WOUT_W  = 14;
    localparam int CIDX_W  = 2;

    // A single input beat never produces more than two triples.
    localparam int BURST_MAX = 6;
    localparam int CNT_W     = 3;

    localparam int MAX_BLOCK_WORDS_DEF = 4096;

    localparam logic [WORD_W-1:0] TAG_RESET     = 16'hABCD;
    localparam logic [RUN_W-1:0]  MAX_RUN_RESET = 13'd100;
    localparam logic [MINR_W-1:0] MIN_RUN_RESET = 3'd4;

    localparam logic [WOUT_W-1:0] WORDS_OUT_CAP = 14'd16383;
    localparam logic [CB_W-1:0]   BYTES_CAP     = 15'd32767;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TAG_WORD = 2'd0,
        CFG_MAX_RUN  = 2'd1,
        CFG_MIN_RUN  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [WORD_W-1:0] tag_word;
        logic [RUN_W-1:0]  max_run;
        logic [MINR_W-1:0] min_run;
    } cfg_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][WORD_W-1:0] words;
        logic [CNT_W-1:0]                 count;
        logic                             eob;
        logic [CB_W-1:0]                  cb;
        logic [EB_W-1:0]                  eb;
    } burst_t;

endpackage

>>> rtl/rlew_core.sv
// Input register, run state and the per-word encoding decision of the word run encoder.
module rlew_core #(
    parameter int MAX_BLOCK_WORDS = rlew_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rlew_pkg::cfg_t              cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rlew_pkg::WORD_W-1:0] s_data_word,
    input  logic                        s_is_last,
    input  logic                        burst_free,
    output logic                        burst_load,
    output rlew_pkg::burst_t            burst
);

    localparam int WIW = $clog2(MAX_BLOCK_WORDS + 1);

    logic                        in_valid_reg;
    logic [rlew_pkg::WORD_W-1:0] in_word_reg;
    logic                        in_last_reg;

    logic [rlew_pkg::WORD_W-1:0] run_value_reg, run_value_next;
    logic [rlew_pkg::RUN_W-1:0]  run_length_reg, run_length_next;
    logic [WIW-1:0]              words_in_reg, words_in_next;
    logic [rlew_pkg::WOUT_W-1:0] words_out_reg, words_out_next;

    logic [rlew_pkg::RUN_W-1:0]  cap;
    logic [rlew_pkg::MINR_W-1:0] lo;
    logic                        extend;
    logic                        close_a;
    logic                        trip_a;
    logic                        trip_b;
    logic [rlew_pkg::CNT_W-1:0]  n_a;
    logic [rlew_pkg::CNT_W-1:0]  n_b;
    logic [rlew_pkg::CNT_W-1:0]  n_tot;
    logic [rlew_pkg::WORD_W-1:0] new_val;
    logic [rlew_pkg::RUN_W-1:0]  new_len;
    logic [2:0][rlew_pkg::WORD_W-1:0] wa;
    logic [2:0][rlew_pkg::WORD_W-1:0] wb;
    logic [rlew_pkg::WOUT_W:0]   wo_sum;
    logic [rlew_pkg::WOUT_W-1:0] wo_new;
    logic [rlew_pkg::CB_W:0]     cb_sum;
    logic [WIW-1:0]              wi_new;

    assign burst_load = in_valid_reg && burst_free;
    assign s_ready    = !in_valid_reg || burst_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_word_reg <= s_data_word;
            in_last_reg <= s_is_last;
        end
    end

    always_comb begin
        int j;
        cap = (cfg.max_run == '0) ? rlew_pkg::RUN_W'(1) : cfg.max_run;
        if (cfg.min_run < 3'd2) begin
            lo = 3'd2;
        end else if (cfg.min_run > 3'd4) begin
            lo = 3'd4;
        end else begin
            lo = cfg.min_run;
        end

        extend  = (run_length_reg != '0) && (in_word_reg == run_value_reg)
                  && (run_length_reg < cap);
        close_a = !extend && (run_length_reg != '0);
        trip_a  = (run_length_reg >= rlew_pkg::RUN_W'(lo))
                  || (run_value_reg == cfg.tag_word);
        // A short run is shorter than four words, so its length fits the count.
        n_a = close_a ? (trip_a ? 3'd3 : run_length_reg[2:0]) : 3'd0;

        new_val = extend ? run_value_reg : in_word_reg;
        new_len = extend ? run_length_reg + 1'b1 : rlew_pkg::RUN_W'(1);
        trip_b  = (new_len >= rlew_pkg::RUN_W'(lo)) || (new_val == cfg.tag_word);
        n_b     = in_last_reg ? (trip_b ? 3'd3 : new_len[2:0]) : 3'd0;
        n_tot   = n_a + n_b;

        if (trip_a) begin
            wa = {run_value_reg, rlew_pkg::WORD_W'(run_length_reg), cfg.tag_word};
        end else begin
            wa = {run_value_reg, run_value_reg, run_value_reg};
        end
        if (trip_b) begin
            wb = {new_val, rlew_pkg::WORD_W'(new_len), cfg.tag_word};
        end else begin
            wb = {new_val, new_val, new_val};
        end

        // Words of the closed run come first, then the flushed run.
        for (int i = 0; i < rlew_pkg::BURST_MAX; i++) begin
            j = i - int'(n_a);
            if (i < 3 && i < int'(n_a)) begin
                burst.words[i] = wa[2'(i)];
            end else if (j >= 0 && j < 3) begin
                burst.words[i] = wb[2'(j)];
            end else begin
                burst.words[i] = '0;
            end
        end

        wo_sum = {1'b0, words_out_reg} + (rlew_pkg::WOUT_W + 1)'(n_tot);
        if (wo_sum > {1'b0, rlew_pkg::WORDS_OUT_CAP}) begin
            wo_new = rlew_pkg::WORDS_OUT_CAP;
        end else begin
            wo_new = wo_sum[rlew_pkg::WOUT_W-1:0];
        end
        cb_sum = {1'b0, wo_new, 1'b0} + (rlew_pkg::CB_W + 1)'(2);
        if (cb_sum > {1'b0, rlew_pkg::BYTES_CAP}) begin
            burst.cb = rlew_pkg::BYTES_CAP;
        end else begin
            burst.cb = cb_sum[rlew_pkg::CB_W-1:0];
        end

        if (words_in_reg < WIW'(MAX_BLOCK_WORDS)) begin
            wi_new = words_in_reg + 1'b1;
        end else begin
            wi_new = words_in_reg;
        end
        burst.eb    = rlew_pkg::EB_W'({wi_new, 1'b0});
        burst.count = n_tot;
        burst.eob   = in_last_reg;

        if (in_last_reg) begin
            run_value_next  = '0;
            run_length_next = '0;
            words_in_next   = '0;
            words_out_next  = '0;
        end else begin
            run_value_next  = new_val;
            run_length_next = new_len;
            words_in_next   = wi_new;
            words_out_next  = wo_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_value_reg  <= '0;
            run_length_reg <= '0;
            words_in_reg   <= '0;
            words_out_reg  <= '0;
        end else if (burst_load) begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
            words_in_reg   <= words_in_next;
            words_out_reg  <= words_out_next;
        end
    end

endmodule

>>> rtl/rlew_burst.sv
// Result register that holds the code words of one input beat and sends them one per beat.
module rlew_burst (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        burst_load,
    input  rlew_pkg::burst_t            burst,
    output logic                        burst_free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rlew_pkg::WORD_W-1:0] m_code_word,
    output logic                        m_end_of_block,
    output logic [rlew_pkg::CB_W-1:0]   m_compressed_bytes,
    output logic [rlew_pkg::EB_W-1:0]   m_expanded_bytes
);

    logic [rlew_pkg::BURST_MAX-1:0][rlew_pkg::WORD_W-1:0] words_reg;
    logic [rlew_pkg::CNT_W-1:0]  count_reg;
    logic                        eob_reg;
    logic [rlew_pkg::CB_W-1:0]   cb_reg;
    logic [rlew_pkg::EB_W-1:0]   eb_reg;
    logic                        final_word;

    assign m_valid    = (count_reg != '0);
    assign final_word = (count_reg == rlew_pkg::CNT_W'(1));
    // The register can take a new burst as its last word leaves.
    assign burst_free = (count_reg == '0) || (final_word && m_ready);

    assign m_code_word        = words_reg[0];
    assign m_end_of_block     = eob_reg && final_word;
    assign m_compressed_bytes = m_end_of_block ? cb_reg : '0;
    assign m_expanded_bytes   = m_end_of_block ? eb_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (burst_load) begin
            count_reg <= burst.count;
        end else if (m_valid && m_ready) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (burst_load) begin
            words_reg <= burst.words;
            eob_reg   <= burst.eob;
            cb_reg    <= burst.cb;
            eb_reg    <= burst.eb;
        end else if (m_valid && m_ready) begin
            for (int i = 0; i < rlew_pkg::BURST_MAX - 1; i++) begin
                words_reg[i] <= words_reg[i+1];
            end
            words_reg[rlew_pkg::BURST_MAX-1] <= '0;
        end
    end

endmodule

>>> rtl/rlew_word_run_encoder.sv
// Top level of the tagged word run encoder for 16-bit words.
//
// The encoder takes one 16-bit data word per input beat and gathers equal
// consecutive words into runs of at most max_run words (one if it is zero). A
// closed run of at least min_run words (min_run held within two to four), or
// any run whose value equals tag_word, is sent as the three code words tag,
// count, value; a shorter run is sent as plain literal words. The beat marked
// is_last flushes the open run, and its final code word carries end_of_block
// together with the compressed size (two bytes per code word plus a two-byte
// header) and the expanded size (two bytes per input word); on all other code
// words these size fields read zero. Every input beat yields zero to six code
// words. An input word is registered, encoded combinationally and loaded as a
// whole burst into the result register, which then sends one code word per
// cycle while m_ready is high. Beats that yield at most one code word therefore
// stream back to back; a beat that yields more code words holds the input side
// until they have left through the single output port of the result register.
// The configuration port is always ready; registers should be written only while no beat is in flight.
module rlew_word_run_encoder #(
    parameter int MAX_BLOCK_WORDS = rlew_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rlew_pkg::CIDX_W-1:0] cfg_index,
    input  logic [rlew_pkg::WORD_W-1:0] cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rlew_pkg::WORD_W-1:0] s_data_word,
    input  logic                        s_is_last,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rlew_pkg::WORD_W-1:0] m_code_word,
    output logic                        m_end_of_block,
    output logic [rlew_pkg::CB_W-1:0]   m_compressed_bytes,
    output logic [rlew_pkg::EB_W-1:0]   m_expanded_bytes
);

    rlew_pkg::cfg_t   cfg_reg;
    rlew_pkg::burst_t burst;
    logic             burst_free;
    logic             burst_load;

    // Configuration writes are registered; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tag_word <= rlew_pkg::TAG_RESET;
            cfg_reg.max_run  <= rlew_pkg::MAX_RUN_RESET;
            cfg_reg.min_run  <= rlew_pkg::MIN_RUN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rlew_pkg::CFG_TAG_WORD: begin
                    cfg_reg.tag_word <= cfg_data;
                end
                rlew_pkg::CFG_MAX_RUN: begin
                    cfg_reg.max_run <= cfg_data[rlew_pkg::RUN_W-1:0];
                end
                rlew_pkg::CFG_MIN_RUN: begin
                    cfg_reg.min_run <= cfg_data[rlew_pkg::MINR_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Input register, run state and the encoding decision for one word.
    rlew_core #(
        .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_word (s_data_word),
        .s_is_last   (s_is_last),
        .burst_free  (burst_free),
        .burst_load  (burst_load),
        .burst       (burst)
    );

    // Result register that drains one code word per beat.
    rlew_burst u_burst (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .burst_load         (burst_load),
        .burst              (burst),
        .burst_free         (burst_free),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_code_word        (m_code_word),
        .m_end_of_block     (m_end_of_block),
        .m_compressed_bytes (m_compressed_bytes),
        .m_expanded_bytes   (m_expanded_bytes)
    );

endmodule

>>> rtl/rlew_checker.sv
// Port-level checks of the word run encoder and the bind that attaches them.
module rlew_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rlew_pkg::WORD_W-1:0] m_code_word,
    input logic                        m_end_of_block,
    input logic [rlew_pkg::CB_W-1:0]   m_compressed_bytes,
    input logic [rlew_pkg::EB_W-1:0]   m_expanded_bytes
);

    // A stalled result beat keeps its code word.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_word))
        else $error("code word changed while stalled");

    // Size fields are zero on every word but the final one of a block.
    a_sizes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_block |-> m_compressed_bytes == '0 && m_expanded_bytes == '0)
        else $error("size fields set on a non-final word");

    // The final word always counts the header and at least one input word.
    a_sizes_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_block |->
            m_compressed_bytes >= rlew_pkg::CB_W'(4) && m_expanded_bytes >= rlew_pkg::EB_W'(2)
            && !m_expanded_bytes[0])
        else $error("bad block sizes on the final word");

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rlew_word_run_encoder rlew_checker u_rlew_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_code_word        (m_code_word),
    .m_end_of_block     (m_end_of_block),
    .m_compressed_bytes (m_compressed_bytes),
    .m_expanded_bytes   (m_expanded_bytes)
);
